@@ rtl/text_mask_change_detector_top_assert.svh @@
// ----------------------------------------------------------------------------
// text mask change detector assertion macros
// concurrent checks, clocked on clock and masked during reset
// ----------------------------------------------------------------------------
`ifndef TEXT_MASK_CHANGE_DETECTOR_TOP_ASSERT_SVH
`define TEXT_MASK_CHANGE_DETECTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/tmcd_pkg.sv @@
// ----------------------------------------------------------------------------
// tmcd_pkg
// shared types and constants of the text mask change detector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmcd_pkg;

   localparam int COUNT_W  = 18;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;

   typedef enum logic [2:0] {
      REG_FRAME_WIDTH,
      REG_FRAME_HEIGHT,
      REG_BRIGHT_LEVEL,
      REG_SATURATION_LIMIT,
      REG_DARK_LEVEL,
      REG_MIN_PIXELS,
      REG_CHANGE_PERCENT
   } reg_idx_type;

   typedef struct packed {
      logic [7:0]         bright_level;
      logic [7:0]         saturation_limit;
      logic [7:0]         dark_level;
      logic [COUNT_W-1:0] min_pixels;
      logic [6:0]         change_percent;
   } thr_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_DRAIN,
      BK_REPORT
   } back_state_type;

endpackage

@@ rtl/tmcd_if.sv @@
// ----------------------------------------------------------------------------
// tmcd channel interfaces
// pixel request channel and frame result channel, valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tmcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       frame_start;

   modport source (output valid, red, green, blue, frame_start, input ready);
   modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

interface tmcd_rsp_if;
   logic        valid;
   logic        ready;
   logic        changed;
   logic [17:0] mask_count;
   logic [17:0] previous_count;
   logic [17:0] differ_count;

   modport source (output valid, changed, mask_count, previous_count, differ_count,
                   input ready);
   modport sink   (input valid, changed, mask_count, previous_count, differ_count,
                   output ready);
endinterface

@@ rtl/tmcd_ram.sv @@
// ----------------------------------------------------------------------------
// tmcd_ram
// generic simple dual port ram, one write port, registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmcd_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tmcd_csr.sv @@
// ----------------------------------------------------------------------------
// tmcd_csr
// apb register file: frame size, classification levels and change limits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmcd_csr
   import tmcd_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [CSR_AW-1:0]                paddr,
   input  logic [CSR_DW-1:0]                pwdata,
   output logic [CSR_DW-1:0]                prdata,
   output logic                             pready,
   output logic [$clog2(MAX_WIDTH+1)-1:0]   frame_width,
   output logic [$clog2(MAX_HEIGHT+1)-1:0]  frame_height,
   output thr_type                          thr,
   output logic                             size_wr
);

   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int RST_W = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
   localparam int RST_H = (128 > MAX_HEIGHT) ? MAX_HEIGHT : 128;

   logic [WW-1:0] width_ff,  width_in;
   logic [HW-1:0] height_ff, height_in;
   thr_type       thr_ff,    thr_in;
   logic          wr;
   reg_idx_type   idx;
   logic [31:0]   w_clamp;
   logic [31:0]   h_clamp;

   assign wr     = psel && penable && pwrite;
   assign idx    = reg_idx_type'(paddr[4:2]);
   assign pready = 1'b1;

   always_comb begin
      if (pwdata[10:0] == 11'd0) begin
         w_clamp = 32'd1;
      end else if (32'(pwdata[10:0]) > 32'(MAX_WIDTH)) begin
         w_clamp = 32'(MAX_WIDTH);
      end else begin
         w_clamp = 32'(pwdata[10:0]);
      end
      if (pwdata[7:0] == 8'd0) begin
         h_clamp = 32'd1;
      end else if (32'(pwdata[7:0]) > 32'(MAX_HEIGHT)) begin
         h_clamp = 32'(MAX_HEIGHT);
      end else begin
         h_clamp = 32'(pwdata[7:0]);
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      thr_in    = thr_ff;
      size_wr   = 1'b0;
      if (wr) begin
         case (idx)
            REG_FRAME_WIDTH: begin
               width_in = w_clamp[WW-1:0];
               size_wr  = 1'b1;
            end
            REG_FRAME_HEIGHT: begin
               height_in = h_clamp[HW-1:0];
               size_wr   = 1'b1;
            end
            REG_BRIGHT_LEVEL:     thr_in.bright_level     = pwdata[7:0];
            REG_SATURATION_LIMIT: thr_in.saturation_limit = pwdata[7:0];
            REG_DARK_LEVEL:       thr_in.dark_level       = pwdata[7:0];
            REG_MIN_PIXELS:       thr_in.min_pixels       = pwdata[COUNT_W-1:0];
            REG_CHANGE_PERCENT:   thr_in.change_percent   = pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff                <= WW'(RST_W);
         height_ff               <= HW'(RST_H);
         thr_ff.bright_level     <= 8'd190;
         thr_ff.saturation_limit <= 8'd40;
         thr_ff.dark_level       <= 8'd70;
         thr_ff.min_pixels       <= COUNT_W'(200);
         thr_ff.change_percent   <= 7'd15;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         thr_ff    <= thr_in;
      end
   end

   always_comb begin
      case (idx)
         REG_FRAME_WIDTH:      prdata = CSR_DW'(width_ff);
         REG_FRAME_HEIGHT:     prdata = CSR_DW'(height_ff);
         REG_BRIGHT_LEVEL:     prdata = CSR_DW'(thr_ff.bright_level);
         REG_SATURATION_LIMIT: prdata = CSR_DW'(thr_ff.saturation_limit);
         REG_DARK_LEVEL:       prdata = CSR_DW'(thr_ff.dark_level);
         REG_MIN_PIXELS:       prdata = CSR_DW'(thr_ff.min_pixels);
         REG_CHANGE_PERCENT:   prdata = CSR_DW'(thr_ff.change_percent);
         default:              prdata = '0;
      endcase
   end

   assign frame_width  = width_ff;
   assign frame_height = height_ff;
   assign thr          = thr_ff;

endmodule

@@ rtl/tmcd_front.sv @@
// ----------------------------------------------------------------------------
// tmcd_front
// pixel intake: classification, line buffer write and row decision queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmcd_front
   import tmcd_pkg::*;
#(
   parameter int MAX_WIDTH     = 1024,
   parameter int MAX_HEIGHT    = 128,
   parameter int NEIGHBOR_STEP = 5
) (
   input  logic                                    clock,
   input  logic                                    reset,
   tmcd_req_if.sink                                req,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]          frame_width,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]         frame_height,
   input  thr_type                                 thr,
   input  logic                                    size_wr,
   input  logic                                    back_busy,
   input  logic                                    cmd_take,
   output logic                                    cmd_valid,
   output logic [$clog2(MAX_HEIGHT)-1:0]           cmd_first_row,
   output logic [$clog2(MAX_HEIGHT)-1:0]           cmd_last_row,
   output logic                                    cmd_final,
   output logic [$clog2(2*NEIGHBOR_STEP+1)-1:0]    cmd_first_slot,
   output logic                                    cls_wr_en,
   output logic [$clog2(2*NEIGHBOR_STEP+1)-1:0]    cls_wr_slot,
   output logic [$clog2(MAX_WIDTH)-1:0]            cls_wr_addr,
   output logic [1:0]                              cls_wr_data,
   output logic                                    clear
);

   localparam int L  = 2 * NEIGHBOR_STEP + 1;
   localparam int SB = $clog2(L);
   localparam int CB = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RB = $clog2(MAX_HEIGHT);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   logic [CB-1:0] col_ff,  col_in;
   logic [RB-1:0] row_ff,  row_in;
   logic [SB-1:0] slot_ff, slot_in;
   logic          cmd_v_ff, cmd_v_in;
   logic [RB-1:0] cmd_first_ff, cmd_first_in;
   logic [RB-1:0] cmd_last_ff,  cmd_last_in;
   logic          cmd_final_ff, cmd_final_in;
   logic [SB-1:0] cmd_slot_ff,  cmd_slot_in;

   logic          accept;
   logic          restart;
   logic [CB-1:0] eff_col;
   logic [RB-1:0] eff_row;
   logic [SB-1:0] eff_slot;
   logic [9:0]    sum;
   logic [20:0]   lum_prod;
   logic [7:0]    lum;
   logic [7:0]    hi_rg, lo_rg, hi, lo, spread;
   logic          bright, dark;
   logic [WW-1:0] col_inc;
   logic          row_end, row_last, row_ge_s, push;
   logic [SB-1:0] slot_minus, slot_plus1;

   assign req.ready = !cmd_v_ff && !back_busy;
   assign accept    = req.valid && req.ready;
   assign restart   = req.frame_start || (col_ff == '0 && row_ff == '0);
   assign eff_col   = req.frame_start ? '0 : col_ff;
   assign eff_row   = req.frame_start ? '0 : row_ff;
   assign eff_slot  = req.frame_start ? '0 : slot_ff;

   // average by multiply with 683/2048, exact for sums up to 765
   assign sum      = 10'(req.red) + 10'(req.green) + 10'(req.blue);
   assign lum_prod = 21'(sum) * 21'd683;
   assign lum      = lum_prod[18:11];
   assign hi_rg    = (req.red > req.green) ? req.red : req.green;
   assign lo_rg    = (req.red < req.green) ? req.red : req.green;
   assign hi       = (req.blue > hi_rg) ? req.blue : hi_rg;
   assign lo       = (req.blue < lo_rg) ? req.blue : lo_rg;
   assign spread   = hi - lo;
   assign bright   = (lum > thr.bright_level) && (spread < thr.saturation_limit);
   assign dark     = lum < thr.dark_level;

   assign col_inc    = WW'(eff_col) + WW'(1);
   assign row_end    = col_inc >= frame_width;
   assign row_last   = (HW'(eff_row) + HW'(1)) >= frame_height;
   assign row_ge_s   = 32'(eff_row) >= NEIGHBOR_STEP;
   assign slot_minus = (32'(eff_slot) >= NEIGHBOR_STEP) ? eff_slot - SB'(NEIGHBOR_STEP)
                                                        : eff_slot + SB'(L - NEIGHBOR_STEP);
   assign slot_plus1 = (eff_slot == SB'(L - 1)) ? '0 : eff_slot + SB'(1);
   assign push       = accept && row_end && (row_ge_s || row_last);

   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      slot_in      = slot_ff;
      cmd_v_in     = cmd_v_ff && !cmd_take;
      cmd_first_in = cmd_first_ff;
      cmd_last_in  = cmd_last_ff;
      cmd_final_in = cmd_final_ff;
      cmd_slot_in  = cmd_slot_ff;
      if (size_wr) begin
         col_in  = '0;
         row_in  = '0;
         slot_in = '0;
      end else if (accept) begin
         if (!row_end) begin
            col_in  = eff_col + CB'(1);
            row_in  = eff_row;
            slot_in = eff_slot;
         end else begin
            col_in = '0;
            if (!row_last) begin
               row_in  = eff_row + RB'(1);
               slot_in = slot_plus1;
            end else begin
               row_in  = '0;
               slot_in = '0;
            end
         end
         if (push) begin
            cmd_v_in     = 1'b1;
            cmd_first_in = row_ge_s ? eff_row - RB'(NEIGHBOR_STEP) : '0;
            cmd_last_in  = row_last ? eff_row : eff_row - RB'(NEIGHBOR_STEP);
            cmd_final_in = row_last;
            cmd_slot_in  = row_ge_s ? slot_minus : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         slot_ff  <= '0;
         cmd_v_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         slot_ff  <= slot_in;
         cmd_v_ff <= cmd_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_first_ff <= cmd_first_in;
      cmd_last_ff  <= cmd_last_in;
      cmd_final_ff <= cmd_final_in;
      cmd_slot_ff  <= cmd_slot_in;
   end

   assign cmd_valid      = cmd_v_ff;
   assign cmd_first_row  = cmd_first_ff;
   assign cmd_last_row   = cmd_last_ff;
   assign cmd_final      = cmd_final_ff;
   assign cmd_first_slot = cmd_slot_ff;
   assign cls_wr_en      = accept;
   assign cls_wr_slot    = eff_slot;
   assign cls_wr_addr    = eff_col;
   assign cls_wr_data    = {dark, bright};
   assign clear          = accept && restart;

endmodule

@@ rtl/tmcd_back.sv @@
// ----------------------------------------------------------------------------
// tmcd_back
// row decision: neighbourhood scan, previous mask compare, counts and result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_mask_change_detector_top_assert.svh"

module tmcd_back
   import tmcd_pkg::*;
#(
   parameter int MAX_WIDTH     = 1024,
   parameter int MAX_HEIGHT    = 128,
   parameter int NEIGHBOR_STEP = 5
) (
   input  logic                                               clock,
   input  logic                                               reset,
   tmcd_rsp_if.source                                         rsp,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]                     frame_width,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]                    frame_height,
   input  thr_type                                            thr,
   input  logic                                               size_wr,
   input  logic                                               clear,
   input  logic                                               cmd_valid,
   input  logic [$clog2(MAX_HEIGHT)-1:0]                      cmd_first_row,
   input  logic [$clog2(MAX_HEIGHT)-1:0]                      cmd_last_row,
   input  logic                                               cmd_final,
   input  logic [$clog2(2*NEIGHBOR_STEP+1)-1:0]               cmd_first_slot,
   output logic                                               cmd_take,
   output logic                                               busy,
   output logic [$clog2(MAX_WIDTH)-1:0]                       cls_rd_addr,
   input  logic [2*NEIGHBOR_STEP:0][1:0]                      cls_rd_data
);

   localparam int L   = 2 * NEIGHBOR_STEP + 1;
   localparam int SB  = $clog2(L);
   localparam int CB  = $clog2(MAX_WIDTH);
   localparam int RB  = $clog2(MAX_HEIGHT);
   localparam int CCB = $clog2(MAX_WIDTH + NEIGHBOR_STEP);
   localparam int PIW = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int S   = NEIGHBOR_STEP;

   back_state_type state_ff, state_in;

   logic [CCB-1:0] c_ff;
   logic [RB-1:0]  row_ff, last_ff;
   logic           final_ff;
   logic [SB-1:0]  slot_ff;

   logic           a_v_ff;
   logic [CCB-1:0] a_c_ff;
   logic           a_first_ff, a_top_ok_ff, a_bot_ok_ff;
   logic [SB-1:0]  a_top_ff, a_mid_ff, a_bot_ff;

   logic [L-1:0]   wt_ff, wmb_ff, wmd_ff, wb_ff;
   logic [L-1:0]   nwt, nwmb, nwmd, nwb;

   logic           b_v_ff, b_m_ff;
   logic [PIW-1:0] b_idx_ff, pidx_ff;
   logic           prev_rd;

   logic [COUNT_W-1:0] cur_ff, cur_in, prv_ff, prv_in, dif_ff, dif_in;
   logic               prev_valid_ff;

   logic               rsp_v_ff;
   logic               rsp_changed_ff;
   logic [COUNT_W-1:0] rsp_cur_ff, rsp_prv_ff, rsp_dif_ff;

   logic           issue, load, scan_end;
   logic [CCB-1:0] c_last;
   logic           top_ok, bot_ok;
   logic [SB-1:0]  top_slot, bot_slot, slot_next;
   logic           col_in_frame, x_valid;
   logic           in_t, in_mb, in_md, in_b;
   logic           dark_any, mask;
   logic           p;
   logic [COUNT_W-1:0] big;
   logic [24:0]    lhs, rhs;
   logic           changed;

   assign c_last    = CCB'(frame_width) + CCB'(S - 1);
   assign scan_end  = c_ff == c_last;
   assign top_ok    = 32'(row_ff) >= S;
   assign bot_ok    = (32'(row_ff) + S) < 32'(frame_height);
   assign top_slot  = (32'(slot_ff) >= S) ? slot_ff - SB'(S) : slot_ff + SB'(L - S);
   assign bot_slot  = (32'(slot_ff) + S >= L) ? slot_ff - SB'(L - S) : slot_ff + SB'(S);
   assign slot_next = (slot_ff == SB'(L - 1)) ? '0 : slot_ff + SB'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:   if (cmd_valid) state_in = BK_SCAN;
         BK_SCAN:   if (scan_end && row_ff == last_ff) state_in = BK_DRAIN;
         BK_DRAIN: begin
            if (!a_v_ff && !b_v_ff) state_in = final_ff ? BK_REPORT : BK_IDLE;
         end
         BK_REPORT: if (!rsp_v_ff || rsp.ready) state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy     = 1'b1;
      cmd_take = 1'b0;
      issue    = 1'b0;
      load     = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            busy     = 1'b0;
            cmd_take = cmd_valid;
         end
         BK_SCAN:   issue = 1'b1;
         BK_DRAIN:  ;
         BK_REPORT: load = !rsp_v_ff || rsp.ready;
      endcase
   end

   assign cls_rd_addr = c_ff[CB-1:0];

   // window step: newest column at bit 0, centre at bit S
   assign col_in_frame = a_c_ff < CCB'(frame_width);
   assign x_valid      = 32'(a_c_ff) >= S;
   assign in_t  = col_in_frame && a_top_ok_ff && cls_rd_data[a_top_ff][1];
   assign in_mb = col_in_frame && cls_rd_data[a_mid_ff][0];
   assign in_md = col_in_frame && cls_rd_data[a_mid_ff][1];
   assign in_b  = col_in_frame && a_bot_ok_ff && cls_rd_data[a_bot_ff][1];

   always_comb begin
      if (a_first_ff) begin
         nwt  = L'(in_t);
         nwmb = L'(in_mb);
         nwmd = L'(in_md);
         nwb  = L'(in_b);
      end else begin
         nwt  = {wt_ff[L-2:0],  in_t};
         nwmb = {wmb_ff[L-2:0], in_mb};
         nwmd = {wmd_ff[L-2:0], in_md};
         nwb  = {wb_ff[L-2:0],  in_b};
      end
   end

   assign dark_any = nwt[0] || nwt[S] || nwt[L-1] || nwmd[0] || nwmd[S] || nwmd[L-1]
                     || nwb[0] || nwb[S] || nwb[L-1];
   assign mask     = nwmb[S] && dark_any;

   tmcd_ram #(
      .WIDTH (1),
      .DEPTH (MAX_WIDTH * MAX_HEIGHT)
   ) u_last_mask (
      .clock   (clock),
      .wr_en   (b_v_ff),
      .wr_addr (b_idx_ff),
      .wr_data (b_m_ff),
      .rd_addr (pidx_ff),
      .rd_data (prev_rd)
   );

   assign p      = prev_valid_ff && prev_rd;
   assign cur_in = (b_m_ff && cur_ff != '1) ? cur_ff + COUNT_W'(1) : cur_ff;
   assign prv_in = (p && prv_ff != '1) ? prv_ff + COUNT_W'(1) : prv_ff;
   assign dif_in = ((b_m_ff != p) && dif_ff != '1) ? dif_ff + COUNT_W'(1) : dif_ff;

   assign big = (cur_ff > prv_ff) ? cur_ff : prv_ff;
   assign lhs = 25'(dif_ff) * 25'd100;
   assign rhs = 25'(big) * 25'(thr.change_percent);

   always_comb begin
      priority if (!prev_valid_ff) begin
         changed = 1'b1;
      end else if (big < thr.min_pixels) begin
         changed = 1'b0;
      end else begin
         changed = lhs > rhs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         a_v_ff        <= 1'b0;
         b_v_ff        <= 1'b0;
         rsp_v_ff      <= 1'b0;
         prev_valid_ff <= 1'b0;
         cur_ff        <= '0;
         prv_ff        <= '0;
         dif_ff        <= '0;
         pidx_ff       <= '0;
      end else begin
         state_ff <= state_in;
         a_v_ff   <= issue;
         b_v_ff   <= a_v_ff && x_valid;
         if (load) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_v_ff <= 1'b0;
         end
         if (size_wr) begin
            prev_valid_ff <= 1'b0;
         end else if (load) begin
            prev_valid_ff <= 1'b1;
         end
         if (size_wr || clear) begin
            cur_ff  <= '0;
            prv_ff  <= '0;
            dif_ff  <= '0;
            pidx_ff <= '0;
         end else begin
            if (b_v_ff) begin
               cur_ff <= cur_in;
               prv_ff <= prv_in;
               dif_ff <= dif_in;
            end
            if (a_v_ff && x_valid) begin
               pidx_ff <= pidx_ff + PIW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_take) begin
         c_ff     <= '0;
         row_ff   <= cmd_first_row;
         last_ff  <= cmd_last_row;
         final_ff <= cmd_final;
         slot_ff  <= cmd_first_slot;
      end else if (issue) begin
         if (scan_end) begin
            c_ff    <= '0;
            row_ff  <= row_ff + RB'(1);
            slot_ff <= slot_next;
         end else begin
            c_ff <= c_ff + CCB'(1);
         end
      end
      a_c_ff      <= c_ff;
      a_first_ff  <= c_ff == '0;
      a_top_ff    <= top_slot;
      a_mid_ff    <= slot_ff;
      a_bot_ff    <= bot_slot;
      a_top_ok_ff <= top_ok;
      a_bot_ok_ff <= bot_ok;
      if (a_v_ff) begin
         wt_ff  <= nwt;
         wmb_ff <= nwmb;
         wmd_ff <= nwmd;
         wb_ff  <= nwb;
      end
      b_m_ff   <= mask;
      b_idx_ff <= pidx_ff;
      if (load) begin
         rsp_changed_ff <= changed;
         rsp_cur_ff     <= cur_ff;
         rsp_prv_ff     <= prv_ff;
         rsp_dif_ff     <= dif_ff;
      end
   end

   assign rsp.valid          = rsp_v_ff;
   assign rsp.changed        = rsp_changed_ff;
   assign rsp.mask_count     = rsp_cur_ff;
   assign rsp.previous_count = rsp_prv_ff;
   assign rsp.differ_count   = rsp_dif_ff;

   `ASSERT_IMPL(a_report_drained, state_ff == BK_REPORT, !a_v_ff && !b_v_ff)
   `ASSERT_NEXT(a_stage_order, !a_v_ff, !b_v_ff)
   `ASSERT_IMPL(a_no_cmd_while_busy, cmd_valid && state_ff != BK_IDLE, !clear)
   `ASSERT_NEXT(a_scan_follows_take, cmd_take, state_ff == BK_SCAN)

endmodule

@@ rtl/text_mask_change_detector_top.sv @@
// ----------------------------------------------------------------------------
// text_mask_change_detector_top
// text mask change detector over rgb pixel bands
// ----------------------------------------------------------------------------
// pixels enter on req_chan (valid/ready) in raster order, one transfer each;
// frame_start restarts the frame. one result per frame leaves on rsp_chan.
// registers are written over the apb port while the block is idle; the user
// must keep to this, the block does not enforce it. pixels that do not end
// a row are taken back to back while the back end is idle. at the end of
// row y with y >= step the input stalls while the back end scans row
// y - step against the line buffer, one column a cycle, bounded by the single
// read port of each line buffer row. the last pixel of a frame scans the
// remaining step + 1 rows (fewer for short frames), each over width + step
// columns; the result is registered once the scan pipeline drains, later
// while an older result waits. the result sits in an output register; intake
// continues while it waits, and only the next frame end waits for rsp_chan to
// take it. reset clears position, counts and the previous frame flag; the
// first frame after reset or after a size write reports changed. no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_mask_change_detector_top
   import tmcd_pkg::*;
#(
   parameter int MAX_WIDTH     = 1024,
   parameter int MAX_HEIGHT    = 128,
   parameter int NEIGHBOR_STEP = 5
) (
   input  logic              clock,
   input  logic              reset,
   tmcd_req_if.sink          req_chan,
   tmcd_rsp_if.source        rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   localparam int L  = 2 * NEIGHBOR_STEP + 1;
   localparam int SB = $clog2(L);
   localparam int CB = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RB = $clog2(MAX_HEIGHT);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   logic [WW-1:0]       frame_width;
   logic [HW-1:0]       frame_height;
   thr_type             thr;
   logic                size_wr;
   logic                back_busy, cmd_take, cmd_valid, cmd_final, clear;
   logic [RB-1:0]       cmd_first_row, cmd_last_row;
   logic [SB-1:0]       cmd_first_slot;
   logic                cls_wr_en;
   logic [SB-1:0]       cls_wr_slot;
   logic [CB-1:0]       cls_wr_addr, cls_rd_addr;
   logic [1:0]          cls_wr_data;
   logic [L-1:0][1:0]   cls_rd_data;

   tmcd_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .frame_width  (frame_width),
      .frame_height (frame_height),
      .thr          (thr),
      .size_wr      (size_wr)
   );

   tmcd_front #(
      .MAX_WIDTH     (MAX_WIDTH),
      .MAX_HEIGHT    (MAX_HEIGHT),
      .NEIGHBOR_STEP (NEIGHBOR_STEP)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req            (req_chan),
      .frame_width    (frame_width),
      .frame_height   (frame_height),
      .thr            (thr),
      .size_wr        (size_wr),
      .back_busy      (back_busy),
      .cmd_take       (cmd_take),
      .cmd_valid      (cmd_valid),
      .cmd_first_row  (cmd_first_row),
      .cmd_last_row   (cmd_last_row),
      .cmd_final      (cmd_final),
      .cmd_first_slot (cmd_first_slot),
      .cls_wr_en      (cls_wr_en),
      .cls_wr_slot    (cls_wr_slot),
      .cls_wr_addr    (cls_wr_addr),
      .cls_wr_data    (cls_wr_data),
      .clear          (clear)
   );

   // one line buffer row per ram, all read at the same column
   for (genvar i = 0; i < L; i++) begin : g_line
      tmcd_ram #(
         .WIDTH (2),
         .DEPTH (MAX_WIDTH)
      ) u_line (
         .clock   (clock),
         .wr_en   (cls_wr_en && cls_wr_slot == SB'(i)),
         .wr_addr (cls_wr_addr),
         .wr_data (cls_wr_data),
         .rd_addr (cls_rd_addr),
         .rd_data (cls_rd_data[i])
      );
   end

   tmcd_back #(
      .MAX_WIDTH     (MAX_WIDTH),
      .MAX_HEIGHT    (MAX_HEIGHT),
      .NEIGHBOR_STEP (NEIGHBOR_STEP)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .rsp            (rsp_chan),
      .frame_width    (frame_width),
      .frame_height   (frame_height),
      .thr            (thr),
      .size_wr        (size_wr),
      .clear          (clear),
      .cmd_valid      (cmd_valid),
      .cmd_first_row  (cmd_first_row),
      .cmd_last_row   (cmd_last_row),
      .cmd_final      (cmd_final),
      .cmd_first_slot (cmd_first_slot),
      .cmd_take       (cmd_take),
      .busy           (back_busy),
      .cls_rd_addr    (cls_rd_addr),
      .cls_rd_data    (cls_rd_data)
   );

endmodule
